// ===== hdl/multi_waveform_phase_oscillator_core_macros.svh =====
`ifndef MULTI_WAVEFORM_PHASE_OSCILLATOR_CORE_MACROS_SVH
`define MULTI_WAVEFORM_PHASE_OSCILLATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MWPO_ASSERT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define MWPO_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hdl/mwpo_pkg.sv =====
package mwpo_pkg;

  // waveform codes
  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_SQUARE   = 2'd3
  } wave_e;

  // register map
  typedef enum logic {
    REG_PHASE_INC = 1'b0,
    REG_WAVE_SEL  = 1'b1
  } reg_e;

  // classified word between front and back
  typedef struct packed {
    wave_e       wave;
    logic        neg;
    logic [31:0] opnd;
  } op_t;

  localparam int unsigned OP_BITS      = $bits(op_t);
  localparam int unsigned CMD_DEPTH    = 2;
  localparam int unsigned OUT_DEPTH    = 4;
  localparam int unsigned OUT_CNT_BITS = $clog2(OUT_DEPTH) + 1;

  localparam logic [31:0] PHASE_INC_RESET = 32'd39370534;
  localparam logic [31:0] HALF_CYCLE      = 32'h8000_0000;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;

  // q30 sine by taylor series through x^13, each term floored
  function automatic logic signed [63:0] sine_q30(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    return sum;
  endfunction

endpackage

// ===== hdl/mwpo_fifo.sv =====
module mwpo_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     pop_i,
  output logic [WIDTH-1:0]         rdata_o,
  output logic                     full_o,
  output logic                     empty_o,
  output logic [$clog2(DEPTH):0]   count_o
);

  localparam int unsigned PTR_BITS = $clog2(DEPTH);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_BITS:0]   count_q, count_d;
  logic                do_push, do_pop;

  // handshake qualification
  assign full_o  = (count_q == (PTR_BITS + 1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PTR_BITS + 1)'(do_push) - (PTR_BITS + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/mwpo_front.sv =====
module mwpo_front #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  restart_i,
  input  logic                  cmd_full_i,
  input  logic [31:0]           phase_inc_i,
  input  mwpo_pkg::wave_e       wave_sel_i,
  output logic                  cmd_push_o,
  output mwpo_pkg::op_t         cmd_op_o
);

  localparam int unsigned TAB_N = 1 << SINE_TABLE_BITS;

  logic [PHASE_BITS-1:0]      phase_q, phase_d;
  logic [PHASE_BITS-1:0]      phase_cur;
  logic [PHASE_BITS-1:0]      phase_step;
  logic [31:0]                frac;
  logic [SINE_TABLE_BITS-1:0] tab_j;
  logic [SINE_TABLE_BITS:0]   tab_idx;
  logic [31:0]                tri_dist;

  assign cmd_push_o = push_i & ~cmd_full_i;

  // restart clears the phase before this word's sample
  assign phase_cur = restart_i ? '0 : phase_q;
  assign phase_d   = phase_cur + phase_step;

  // step scaling and 32-bit phase fraction
  if (PHASE_BITS >= 32) begin : g_wide
    assign phase_step = PHASE_BITS'(phase_inc_i) << (PHASE_BITS - 32);
    assign frac       = phase_cur[PHASE_BITS-1 -: 32];
  end else begin : g_narrow
    assign phase_step = PHASE_BITS'(phase_inc_i >> (32 - PHASE_BITS));
    assign frac       = 32'(phase_cur) << (32 - PHASE_BITS);
  end

  // quarter-wave index, mirrored in the odd quadrants
  assign tab_j   = frac[29 -: SINE_TABLE_BITS];
  assign tab_idx = frac[30] ? (SINE_TABLE_BITS + 1)'(TAB_N) - {1'b0, tab_j}
                            : {1'b0, tab_j};

  // distance from half cycle for the triangle
  assign tri_dist = frac[31] ? {1'b0, frac[30:0]} : mwpo_pkg::HALF_CYCLE - frac;

  // classify the word for the back end
  always_comb begin
    cmd_op_o.wave = wave_sel_i;
    case (wave_sel_i)
      mwpo_pkg::WAVE_SINE: begin
        cmd_op_o.neg  = frac[31];
        cmd_op_o.opnd = 32'(tab_idx);
      end
      mwpo_pkg::WAVE_TRIANGLE: begin
        cmd_op_o.neg  = 1'b0;
        cmd_op_o.opnd = tri_dist;
      end
      mwpo_pkg::WAVE_SAW: begin
        cmd_op_o.neg  = 1'b0;
        cmd_op_o.opnd = frac;
      end
      default: begin
        cmd_op_o.neg  = frac[31];
        cmd_op_o.opnd = frac;
      end
    endcase
  end

  // phase accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cmd_push_o) begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== hdl/mwpo_back.sv =====
`include "multi_waveform_phase_oscillator_core_macros.svh"

module mwpo_back #(
  parameter int unsigned SINE_TABLE_BITS = 8,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_empty_i,
  input  mwpo_pkg::op_t                     cmd_op_i,
  output logic                              cmd_pop_o,
  input  logic [mwpo_pkg::OUT_CNT_BITS-1:0] out_count_i,
  output logic                              out_push_o,
  output logic signed [SAMPLE_BITS-1:0]     sample_o
);

  localparam int unsigned TAB_N    = 1 << SINE_TABLE_BITS;
  localparam int unsigned RAW_BITS = SAMPLE_BITS + 31;
  localparam logic [SAMPLE_BITS-2:0] FULL_SCALE = '1;
  localparam logic [SAMPLE_BITS-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // one quarter-wave table entry, rounded half up and clamped to full scale
  function automatic logic [SAMPLE_BITS-2:0] tab_entry(input int unsigned idx);
    logic [63:0]        x;
    logic signed [63:0] s;
    logic [63:0]        v;
    x = (mwpo_pkg::HALF_PI_Q30 * 64'(idx)) >> SINE_TABLE_BITS;
    s = mwpo_pkg::sine_q30(x);
    if (s < 0) begin
      s = '0;
    end
    v = ((64'(s) * 64'(FULL_SCALE)) + (64'd1 << 29)) >> 30;
    if (v > 64'(FULL_SCALE)) begin
      v = 64'(FULL_SCALE);
    end
    return v[SAMPLE_BITS-2:0];
  endfunction

  logic [SAMPLE_BITS-2:0] sine_tab [TAB_N + 1];

  // constant quarter-wave table
  for (genvar gi = 0; gi <= TAB_N; gi++) begin : g_tab
    assign sine_tab[gi] = tab_entry(gi);
  end

  logic                  s1_valid_q;
  mwpo_pkg::wave_e       s1_wave_q;
  logic                  s1_neg_q;
  logic [RAW_BITS-1:0]   s1_raw_q, s1_raw_d;
  logic [SAMPLE_BITS:0]  result;

  // take a word only when the result queue has room for everything in flight
  assign cmd_pop_o = ~cmd_empty_i &
                     ((out_count_i + mwpo_pkg::OUT_CNT_BITS'(s1_valid_q)) <
                      mwpo_pkg::OUT_CNT_BITS'(mwpo_pkg::OUT_DEPTH));

  // table read or scale multiply
  always_comb begin
    if (cmd_op_i.wave == mwpo_pkg::WAVE_SINE) begin
      s1_raw_d = RAW_BITS'(sine_tab[cmd_op_i.opnd[SINE_TABLE_BITS:0]]);
    end else begin
      s1_raw_d = RAW_BITS'(cmd_op_i.opnd) * RAW_BITS'(FULL_SCALE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      s1_wave_q <= cmd_op_i.wave;
      s1_neg_q  <= cmd_op_i.neg;
      s1_raw_q  <= s1_raw_d;
    end
  end

  // final offset and sign
  always_comb begin
    case (s1_wave_q)
      mwpo_pkg::WAVE_SINE: begin
        result = s1_neg_q ? -{2'b00, s1_raw_q[SAMPLE_BITS-2:0]}
                          : {2'b00, s1_raw_q[SAMPLE_BITS-2:0]};
      end
      mwpo_pkg::WAVE_TRIANGLE: begin
        result = {1'b0, s1_raw_q[30 +: SAMPLE_BITS]} - {2'b00, FULL_SCALE};
      end
      mwpo_pkg::WAVE_SAW: begin
        result = {1'b0, s1_raw_q[31 +: SAMPLE_BITS]} - {2'b00, FULL_SCALE};
      end
      default: begin
        result = s1_neg_q ? -{2'b00, FULL_SCALE} : {2'b00, FULL_SCALE};
      end
    endcase
  end

  assign out_push_o = s1_valid_q;
  assign sample_o   = $signed(result[SAMPLE_BITS-1:0]);

  // checks
  `MWPO_ASSERT(a_out_room, s1_valid_q, out_count_i < mwpo_pkg::OUT_CNT_BITS'(mwpo_pkg::OUT_DEPTH))
  `MWPO_ASSERT_NEXT(a_pop_fills_stage, cmd_pop_o, s1_valid_q)
  `MWPO_ASSERT(a_sample_range, s1_valid_q, sample_o != MIN_SAMPLE)

endmodule

// ===== hdl/multi_waveform_phase_oscillator_core.sv =====
// multi-waveform phase-accumulator oscillator
// input queue: push with restart_i while full is low; each word is one sample tick.
//   restart_i high clears the phase before that tick's sample.
// result queue: sample_value_o holds the oldest sample while empty is low; pop takes it.
// config: apb writes at 0x0 (phase increment, 32 bits) and 0x4 (waveform select:
//   sine, triangle, sawtooth, square); pready is always high, reads return the value.
//   write config only while no word is in flight.
// path: a pushed word passes the command queue, the back register and the result queue.
// throughput: one word per cycle while pop keeps up; the phase add plus classify
//   sit in the front, one table read or one scale multiply per word in the back.
// a two-entry command queue parts front and back, a four-entry result queue parts
//   the back from the receiver; when pop stays low the result queue fills, the back
//   stops, the command queue fills and full rises.
// reset: phase zero, increment 39370534 (440 Hz at 48 kHz), sine, both queues empty.
module multi_waveform_phase_oscillator_core #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 8,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input queue side
  input  logic                          push,
  output logic                          full,
  input  logic                          restart_i,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] sample_value_o,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [31:0]                       phase_inc_q;
  logic [1:0]                        wave_sel_q;
  logic                              cfg_write;
  mwpo_pkg::reg_e                    cfg_reg;

  logic                              cmd_push;
  mwpo_pkg::op_t                     cmd_op_in;
  logic [mwpo_pkg::OP_BITS-1:0]      cmd_rdata;
  logic                              cmd_pop;
  logic                              cmd_empty;
  logic [$clog2(mwpo_pkg::CMD_DEPTH):0] cmd_count;

  logic                              out_push;
  logic signed [SAMPLE_BITS-1:0]     out_sample;
  logic [SAMPLE_BITS-1:0]            out_rdata;
  logic                              out_full;
  logic [mwpo_pkg::OUT_CNT_BITS-1:0] out_count;

  // register access
  assign pready    = 1'b1;
  assign cfg_reg   = mwpo_pkg::reg_e'(paddr[2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    case (cfg_reg)
      mwpo_pkg::REG_PHASE_INC: prdata = phase_inc_q;
      mwpo_pkg::REG_WAVE_SEL:  prdata = {30'd0, wave_sel_q};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= mwpo_pkg::PHASE_INC_RESET;
      wave_sel_q  <= mwpo_pkg::WAVE_SINE;
    end else if (cfg_write) begin
      case (cfg_reg)
        mwpo_pkg::REG_PHASE_INC: phase_inc_q <= pwdata;
        mwpo_pkg::REG_WAVE_SEL:  wave_sel_q  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // front: phase accumulation and classification
  mwpo_front #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .restart_i   (restart_i),
    .cmd_full_i  (full),
    .phase_inc_i (phase_inc_q),
    .wave_sel_i  (mwpo_pkg::wave_e'(wave_sel_q)),
    .cmd_push_o  (cmd_push),
    .cmd_op_o    (cmd_op_in)
  );

  // command queue between front and back
  mwpo_fifo #(
    .WIDTH (mwpo_pkg::OP_BITS),
    .DEPTH (mwpo_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_op_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .full_o  (full),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  // back: waveform evaluation
  mwpo_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty | (cmd_count == '0)),
    .cmd_op_i    (mwpo_pkg::op_t'(cmd_rdata)),
    .cmd_pop_o   (cmd_pop),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .sample_o    (out_sample)
  );

  // result queue
  mwpo_fifo #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (mwpo_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push & ~out_full),
    .wdata_i (out_sample),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .full_o  (out_full),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign sample_value_o = $signed(out_rdata);

endmodule
